// ----- src/circular_token_match_score_macros.svh -----
// Assertion helpers for the RTL.
`ifndef CIRCULAR_TOKEN_MATCH_SCORE_MACROS_SVH
`define CIRCULAR_TOKEN_MATCH_SCORE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define CTMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CTMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/ctms_pkg.sv -----
package ctms_pkg;

   localparam int SYM_W   = 8;
   localparam int FRAC_W  = 16;
   localparam int RATIO_W = 17;
   localparam int COUNT_W = 9;

   localparam logic [1:0] FUNC_FIRST  = 2'd0;
   localparam logic [1:0] FUNC_SECOND = 2'd1;
   localparam logic [1:0] FUNC_RUN    = 2'd2;

   typedef struct packed {
      logic [1:0]       func;
      logic [SYM_W-1:0] symbol;
      logic             mode;
   } req_type;

   typedef struct packed {
      logic [RATIO_W-1:0] ratio;
      logic [COUNT_W-1:0] best_count;
      logic               empty_error;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic             second;
      logic [SYM_W-1:0] symbol;
   } wr_type;

   typedef struct packed {
      logic go;
      logic mode;
   } scan_go_type;

endpackage

// ----- src/ctms_scan.sv -----
module ctms_scan #(
   parameter int MAX_LEN = 256,
   localparam int ADDR_W = $clog2(MAX_LEN),
   localparam int LEN_W  = $clog2(MAX_LEN + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctms_pkg::scan_go_type go,
   input  ctms_pkg::wr_type      wr,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [LEN_W-1:0]      first_len,
   input  logic [LEN_W-1:0]      second_len,
   output logic                  done,
   output logic [LEN_W-1:0]      best
);
   import ctms_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} state_type;

   logic [SYM_W-1:0] first_mem  [MAX_LEN];
   logic [SYM_W-1:0] second_mem [MAX_LEN];

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] m_ff, m_in, n_ff, n_in;
   logic             swap_ff, swap_in, mode_ff, mode_in;
   logic [ADDR_W-1:0] j_ff, j_in, r_ff, r_in, idx_ff, idx_in;
   logic             iss_valid_ff, iss_valid_in;
   logic             iss_first_ff, iss_first_in, iss_last_ff, iss_last_in;
   logic [SYM_W-1:0] first_rd_ff, second_rd_ff;
   logic [LEN_W-1:0] count_ff, count_in, run_ff, run_in, long_ff, long_in;
   logic [LEN_W-1:0] best_ff, best_in;

   logic [ADDR_W-1:0] addr_first, addr_second;
   logic             last_j, last_r, idx_wrap, eq;
   logic [LEN_W-1:0] base_count, base_run, base_long, score;

   assign last_j      = (LEN_W'(j_ff) + LEN_W'(1)) == n_ff;
   assign last_r      = (LEN_W'(r_ff) + LEN_W'(1)) == m_ff;
   assign idx_wrap    = (LEN_W'(idx_ff) + LEN_W'(1)) == m_ff;
   assign addr_first  = swap_ff ? j_ff : idx_ff;
   assign addr_second = swap_ff ? idx_ff : j_ff;

   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      swap_in      = swap_ff;
      mode_in      = mode_ff;
      j_in         = j_ff;
      r_in         = r_ff;
      idx_in       = idx_ff;
      iss_valid_in = 1'b0;
      iss_first_in = iss_first_ff;
      iss_last_in  = iss_last_ff;
      count_in     = count_ff;
      run_in       = run_ff;
      long_in      = long_ff;
      best_in      = best_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (go.go) begin
               swap_in  = first_len < second_len;
               m_in     = swap_in ? second_len : first_len;
               n_in     = swap_in ? first_len : second_len;
               mode_in  = go.mode;
               j_in     = '0;
               r_in     = '0;
               idx_in   = '0;
               best_in  = '0;
               state_in = (n_in == '0) ? S_DONE : S_RUN;
            end
         end
         S_RUN: begin
            iss_valid_in = 1'b1;
            iss_first_in = j_ff == '0;
            iss_last_in  = last_j;
            if (last_j) begin
               // next rotation starts its long-string walk at r + 1
               j_in   = '0;
               r_in   = r_ff + ADDR_W'(1);
               idx_in = r_ff + ADDR_W'(1);
               if (last_r) begin
                  state_in = S_DRAIN;
               end
            end else begin
               j_in   = j_ff + ADDR_W'(1);
               idx_in = idx_wrap ? '0 : idx_ff + ADDR_W'(1);
            end
         end
         S_DRAIN: state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase

      // compare stage: one symbol pair per cycle
      eq         = first_rd_ff == second_rd_ff;
      base_count = iss_first_ff ? '0 : count_ff;
      base_run   = iss_first_ff ? '0 : run_ff;
      base_long  = iss_first_ff ? '0 : long_ff;
      score      = '0;
      if (iss_valid_ff) begin
         count_in = base_count + LEN_W'(eq);
         run_in   = eq ? base_run + LEN_W'(1) : '0;
         long_in  = (run_in > base_long) ? run_in : base_long;
         score    = mode_ff ? long_in : count_in;
         if (iss_last_ff && score > best_ff) begin
            best_in = score;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iss_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_valid_ff <= iss_valid_in;
      end
      m_ff         <= m_in;
      n_ff         <= n_in;
      swap_ff      <= swap_in;
      mode_ff      <= mode_in;
      j_ff         <= j_in;
      r_ff         <= r_in;
      idx_ff       <= idx_in;
      iss_first_ff <= iss_first_in;
      iss_last_ff  <= iss_last_in;
      count_ff     <= count_in;
      run_ff       <= run_in;
      long_ff      <= long_in;
      best_ff      <= best_in;
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         if (wr.second) begin
            second_mem[wr_addr] <= wr.symbol;
         end else begin
            first_mem[wr_addr] <= wr.symbol;
         end
      end
      first_rd_ff  <= first_mem[addr_first];
      second_rd_ff <= second_mem[addr_second];
   end

   assign done = state_ff == S_DONE;
   assign best = best_ff;

endmodule

// ----- src/ctms_div.sv -----
module ctms_div #(
   parameter int LEN_W = 9,
   localparam int DW    = LEN_W + ctms_pkg::FRAC_W,
   localparam int CNT_W = $clog2(DW + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [LEN_W-1:0] dividend,
   input  logic [LEN_W-1:0] divisor,
   output logic             done,
   output logic [DW-1:0]    quotient
);
   import ctms_pkg::*;

   typedef enum logic {D_IDLE, D_RUN} state_type;

   state_type        state_ff, state_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    dvd_ff, dvd_in;
   logic [LEN_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [LEN_W:0]   trial;
   logic             ge;

   // restoring division, one quotient bit per cycle shifted into the dividend register
   assign trial = {rem_ff, dvd_ff[DW-1]};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               dvd_in   = {dividend, {FRAC_W{1'b0}}};
               rem_in   = '0;
               div_in   = divisor;
               cnt_in   = CNT_W'(DW);
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in = ge ? LEN_W'(trial - {1'b0, div_ff}) : LEN_W'(trial);
            dvd_in = {dvd_ff[DW-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ----- src/circular_token_match_score.sv -----
// Load requests may follow back to back; requests stall while a run request is in progress,
// until its result is registered. Scan: one symbol pair per cycle through the shared compare
// stage over m*n pairs, m and n the longer and shorter string lengths; divide: one quotient
// bit per cycle for LEN_W + 16 quotient bits, LEN_W = clog2(MAX_LEN+1). A stalled output
// holds the next result back.
// Reset empties both strings by clearing their lengths; symbol stores are not cleared.
`include "circular_token_match_score_macros.svh"

module circular_token_match_score #(
   parameter int MAX_LEN = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ctms_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ctms_pkg::rsp_type rsp_data
);
   import ctms_pkg::*;

   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int DW     = LEN_W + FRAC_W;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_OUT} state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] first_len_ff, first_len_in, second_len_ff, second_len_in;
   logic             empty_ff, empty_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_ok;
   wr_type           wr;
   logic [ADDR_W-1:0] wr_addr;
   scan_go_type      go;
   logic             scan_done, div_start, div_done;
   logic [LEN_W-1:0] best;
   logic [DW-1:0]    quot;

   assign req_stall = state_ff != ST_IDLE;
   assign req_ok    = req_valid && !req_stall;

   always_comb begin
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      wr            = '0;
      wr_addr       = first_len_ff[ADDR_W-1:0];
      go.go         = 1'b0;
      go.mode       = req_data.mode;
      if (req_ok) begin
         unique case (req_data.func)
            FUNC_FIRST: begin
               // drop symbols once the store is full
               if (first_len_ff < LEN_W'(MAX_LEN)) begin
                  wr.en        = 1'b1;
                  wr.symbol    = req_data.symbol;
                  first_len_in = first_len_ff + LEN_W'(1);
               end
            end
            FUNC_SECOND: begin
               if (second_len_ff < LEN_W'(MAX_LEN)) begin
                  wr.en         = 1'b1;
                  wr.second     = 1'b1;
                  wr.symbol     = req_data.symbol;
                  wr_addr       = second_len_ff[ADDR_W-1:0];
                  second_len_in = second_len_ff + LEN_W'(1);
               end
            end
            FUNC_RUN: go.go = 1'b1;
            default: go.go = 1'b0;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      empty_in     = empty_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (go.go) begin
               empty_in = first_len_ff == '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold the result until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.ratio       = empty_ff ? '0 : RATIO_W'(quot);
               rsp_data_in.best_count  = COUNT_W'(best);
               rsp_data_in.empty_error = empty_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         first_len_ff  <= '0;
         second_len_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
      end
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
   end

   ctms_scan #(.MAX_LEN(MAX_LEN)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .wr         (wr),
      .wr_addr    (wr_addr),
      .first_len  (first_len_ff),
      .second_len (second_len_ff),
      .done       (scan_done),
      .best       (best)
   );

   ctms_div #(.LEN_W(LEN_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (best),
      .divisor  (first_len_ff),
      .done     (div_done),
      .quotient (quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CTMS_ASSERT_SAME(a_empty_zero, clock, reset,
      rsp_valid && rsp_data.empty_error,
      (rsp_data.ratio == '0) && (rsp_data.best_count == '0),
      "empty first string with nonzero result")
   `CTMS_ASSERT_SAME(a_scan_done, clock, reset, scan_done, state_ff == ST_SCAN,
      "scan finished outside scan phase")
   `CTMS_ASSERT_SAME(a_div_done, clock, reset, div_done, state_ff == ST_DIV,
      "divide finished outside divide phase")
   `CTMS_ASSERT_SAME(a_len_bound, clock, reset, 1'b1,
      (first_len_ff <= LEN_W'(MAX_LEN)) && (second_len_ff <= LEN_W'(MAX_LEN)),
      "string length past store depth")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import ctms_pkg::*;

   localparam int MAX_LEN = 256;
   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 100;

   class match_scoreboard;
      logic [SYM_W-1:0] first_sym [MAX_LEN];
      logic [SYM_W-1:0] second_sym [MAX_LEN];
      int unsigned first_len = 0;
      int unsigned second_len = 0;
      rsp_type expected_scores[$];
      int unsigned errors = 0;

      // Slide the shorter string over every rotation of the longer one.
      function int unsigned rotation_best(bit longest_mode);
         int unsigned m, n, best, hits, streak, longest, idx, score;
         bit first_short;
         logic [SYM_W-1:0] s_sym, l_sym;
         first_short = first_len < second_len;
         m = first_short ? second_len : first_len;
         n = first_short ? first_len : second_len;
         best = 0;
         for (int unsigned r = 0; r < m; r++) begin
            hits = 0;
            streak = 0;
            longest = 0;
            idx = r;
            for (int unsigned j = 0; j < n; j++) begin
               s_sym = first_short ? first_sym[j] : second_sym[j];
               l_sym = first_short ? second_sym[idx] : first_sym[idx];
               if (s_sym == l_sym) begin
                  hits++;
                  streak++;
                  if (streak > longest) longest = streak;
               end else begin
                  streak = 0;
               end
               idx = (idx + 1 == m) ? 0 : idx + 1;
            end
            score = longest_mode ? longest : hits;
            if (score > best) best = score;
         end
         return best;
      endfunction

      function void note_request(req_type item);
         rsp_type want;
         int unsigned best;
         longint unsigned quotient;
         unique case (item.func)
            FUNC_FIRST: begin
               // drop symbols once the store is full
               if (first_len < MAX_LEN) begin
                  first_sym[first_len] = item.symbol;
                  first_len++;
               end
            end
            FUNC_SECOND: begin
               if (second_len < MAX_LEN) begin
                  second_sym[second_len] = item.symbol;
                  second_len++;
               end
            end
            FUNC_RUN: begin
               best = rotation_best(item.mode);
               quotient = (first_len == 0) ? 0 :
                  (longint'(best) << FRAC_W) / longint'(first_len);
               want.ratio = quotient[RATIO_W-1:0];
               want.best_count = best[COUNT_W-1:0];
               want.empty_error = (first_len == 0);
               expected_scores = {expected_scores, want};
            end
            default: begin
            end
         endcase
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_scores.size() == 0) begin
            $error("unexpected response: ratio %0d best_count %0d empty_error %0d",
               got.ratio, got.best_count, got.empty_error);
            errors++;
            return;
         end
         want = expected_scores.pop_front();
         if (got.ratio !== want.ratio) begin
            $error("ratio: expected %0d, got %0d", want.ratio, got.ratio);
            errors++;
         end
         if (got.best_count !== want.best_count) begin
            $error("best_count: expected %0d, got %0d", want.best_count, got.best_count);
            errors++;
         end
         if (got.empty_error !== want.empty_error) begin
            $error("empty_error: expected %0d, got %0d", want.empty_error, got.empty_error);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;

   match_scoreboard board;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_requests = 0;

   circular_token_match_score #(
      .MAX_LEN(MAX_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("testbench: errors");
      $finish;
   end

   // Small alphabet most of the time so rotations actually match.
   function automatic logic [SYM_W-1:0] pick_symbol();
      unique case ($urandom_range(4))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h5A;
         3: return 8'hA5;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_fields(input logic [1:0] func, input logic [SYM_W-1:0] symbol,
                              input logic mode);
      req_type item;
      item.func = func;
      item.symbol = symbol;
      item.mode = mode;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      board.note_request(item);
   endtask

   task automatic random_items(input int unsigned count, input int unsigned cap);
      int unsigned sent, pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_fields(FUNC_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else begin
            if (pick < 30 && board.first_len < cap)
               send_fields(FUNC_FIRST, pick_symbol(), 1'($urandom_range(1)));
            else if (pick < 52 && board.second_len < cap)
               send_fields(FUNC_SECOND, pick_symbol(), 1'($urandom_range(1)));
            else
               send_fields(FUNC_RUN, 8'($urandom_range(255)), 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   // Receiver: check, then pick the stall for the next cycle.
   initial begin
      int unsigned hold_seen;
      int unsigned hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      int unsigned extra;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 69;
      // both strings empty
      send_fields(FUNC_RUN, 8'h00, 1'b0);
      send_fields(FUNC_RUN, 8'hFF, 1'b1);
      send_fields(FUNC_NONE, 8'hFF, 1'b1);
      // first string empty, second not
      send_fields(FUNC_SECOND, 8'h00, 1'b0);
      send_fields(FUNC_SECOND, 8'hFF, 1'b1);
      send_fields(FUNC_RUN, 8'h00, 1'b0);
      send_fields(FUNC_RUN, 8'h00, 1'b1);
      // one-symbol first string fully matched: ratio at its top
      send_fields(FUNC_FIRST, 8'hFF, 1'b1);
      send_fields(FUNC_RUN, 8'hFF, 1'b0);
      send_fields(FUNC_RUN, 8'h00, 1'b1);
      // equal lengths, first plays the longer string
      send_fields(FUNC_FIRST, 8'h00, 1'b0);
      send_fields(FUNC_RUN, 8'h5A, 1'b0);
      send_fields(FUNC_RUN, 8'hA5, 1'b1);
      send_fields(FUNC_SECOND, 8'h00, 1'b1);
      send_fields(FUNC_RUN, 8'h00, 1'b0);
      send_fields(FUNC_FIRST, 8'h5A, 1'b0);
      send_fields(FUNC_FIRST, 8'hA5, 1'b1);
      send_fields(FUNC_FIRST, 8'h5A, 1'b0);
      send_fields(FUNC_RUN, 8'hFF, 1'b0);
      send_fields(FUNC_RUN, 8'h00, 1'b1);
      send_fields(FUNC_NONE, 8'h00, 1'b0);

      random_items(60, 8);

      send_idle_pct = 69;
      recv_idle_pct = 29;
      random_items(60, 16);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // long receiver hold while requests keep coming
      hold_requests++;
      random_items(60, 32);

      // fill both stores past their depth, then run on the full sizes
      extra = MAX_LEN - board.first_len + 3;
      repeat (extra) send_fields(FUNC_FIRST, pick_symbol(), 1'($urandom_range(1)));
      send_fields(FUNC_RUN, 8'($urandom_range(255)), 1'b0);
      send_fields(FUNC_RUN, 8'($urandom_range(255)), 1'b1);
      extra = MAX_LEN - board.second_len + 2;
      repeat (extra) send_fields(FUNC_SECOND, pick_symbol(), 1'($urandom_range(1)));
      send_fields(FUNC_RUN, 8'($urandom_range(255)), 1'b0);
      send_fields(FUNC_RUN, 8'($urandom_range(255)), 1'b1);
      req_valid <= 1'b0;

      while (board.expected_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ----- circular_token_match_score.f -----
+incdir+src
src/ctms_pkg.sv
src/ctms_scan.sv
src/ctms_div.sv
src/circular_token_match_score.sv
tb/testbench.sv
